@@ hw/rtl/message_to_packet_framer_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the message to packet framer
// Clocked property checks that can be compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef MESSAGE_TO_PACKET_FRAMER_UNIT_ASSERT_SVH
`define MESSAGE_TO_PACKET_FRAMER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Temporal property, checked at every rising edge outside reset
`define MPF_ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Plain invariant, checked at every rising edge outside reset
`define MPF_ASSERT_INV(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

`else

`define MPF_ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define MPF_ASSERT_INV(lbl, clk, rstn, cond, msg)

`endif

`endif

@@ hw/rtl/mpf_pkg.sv @@
// ---------------------------------------------------------------------------
// mpf_pkg
// Types, constants and helpers for the message to packet framer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpf_pkg;

    // Payload slots of a packet are numbered 2..7
    localparam logic [3:0] FIRST_SLOT = 4'd2;
    localparam logic [3:0] SLOT_END   = 4'd8;
    localparam int unsigned PKT_BYTES = 6;

    // Output queue depth
    localparam int unsigned QUEUE_DEPTH = 3;

    // Framing phase of the current message
    typedef enum logic [2:0] {
        PH_LEN     = 3'd0,
        PH_ID      = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_DONE    = 3'd4
    } phase_t;

    // One packet of six bytes, byte 0 in the low bits
    typedef logic [PKT_BYTES-1:0][7:0] pkt_t;

    // 8-bit end-around-carry add
    function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

    // Queue pointer step, wrapping at the queue depth
    function automatic logic [1:0] ptr_inc(input logic [1:0] p);
        return (p == 2'(QUEUE_DEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

endpackage

@@ hw/rtl/message_to_packet_framer_unit.sv @@
// ---------------------------------------------------------------------------
// message_to_packet_framer_unit
// Packs a byte stream (length, id, payload) into six-byte packets with a
// sequence byte up front and an end-around-carry checksum at the end.
// ---------------------------------------------------------------------------
// Takes one message byte per clock while s_tready is high. Each accepted beat
// is framed in the same cycle and the packets it completes (none, one or two)
// land in a three-entry output queue; s_tready is high while that queue holds
// at most one packet, so with a free-running sink a new byte enters every
// cycle, except that input stalls right after a byte that yields two packets.
// Such a byte both fills a packet and ends the message; its two packets leave
// in turn, and the output port, one packet per beat, sets the sustained rate.
// Packet slots not written for a packet carry stale bytes from earlier ones.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "message_to_packet_framer_unit_assert.svh"

module message_to_packet_framer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_of_message
    // Packet stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] packet_byte_0 .. [47:40] packet_byte_5
    output logic        m_tlast    // last_packet
);

    // Framing state
    logic [7:0]          sum_reg,   sum_next;
    logic [7:0]          seq_reg,   seq_next;
    logic [3:0]          fill_reg,  fill_next;
    mpf_pkg::phase_t     phase_reg, phase_next;
    logic [7:0]          len_reg,   len_next;
    logic [7:0]          seen_reg,  seen_next;
    mpf_pkg::pkt_t       store_reg, store_next;

    // Results of the current beat
    mpf_pkg::pkt_t       res0_data, res1_data;
    logic                res0_last, res1_last;
    logic [1:0]          push_cnt;
    logic                chk_due;
    logic [2:0]          widx;

    // Output queue
    logic [47:0]         q_data_reg [mpf_pkg::QUEUE_DEPTH];
    logic                q_last_reg [mpf_pkg::QUEUE_DEPTH];
    logic [1:0]          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]          cnt_reg;

    logic                s_fire, m_fire;

    assign s_fire   = s_tvalid & s_tready;
    assign m_fire   = m_tvalid & m_tready;
    assign s_tready = (cnt_reg <= 2'd1);

    // Framing of one beat: sequence byte, data byte, packet close, checksum
    always_comb begin
        sum_next   = sum_reg;
        seq_next   = seq_reg;
        fill_next  = fill_reg;
        phase_next = phase_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        store_next = store_reg;
        res0_data  = store_reg;
        res1_data  = store_reg;
        res0_last  = 1'b0;
        res1_last  = 1'b1;
        push_cnt   = 2'd0;
        chk_due    = 1'b0;
        widx       = 3'd0;

        if (s_fire) begin
            // start flag restarts framing
            if (s_tuser) begin
                sum_next   = 8'd0;
                seq_next   = 8'd0;
                fill_next  = mpf_pkg::FIRST_SLOT;
                seen_next  = 8'd0;
                phase_next = mpf_pkg::PH_LEN;
            end

            if (phase_next != mpf_pkg::PH_DONE) begin
                // open a packet with its sequence byte
                if (fill_next == mpf_pkg::FIRST_SLOT) begin
                    store_next[0] = seq_next;
                    sum_next      = mpf_pkg::eac_add(sum_next, seq_next);
                    seq_next      = seq_next + 8'd1;
                    fill_next     = fill_next + 4'd1;
                end

                // message byte
                widx             = 3'(fill_next - mpf_pkg::FIRST_SLOT);
                store_next[widx] = s_tdata;
                fill_next        = fill_next + 4'd1;
                sum_next         = mpf_pkg::eac_add(sum_next, s_tdata);

                case (phase_next)
                    mpf_pkg::PH_LEN: begin
                        len_next   = s_tdata;
                        phase_next = mpf_pkg::PH_ID;
                    end
                    mpf_pkg::PH_ID: begin
                        if (len_next == 8'd0) begin
                            chk_due = 1'b1;
                        end else begin
                            phase_next = mpf_pkg::PH_PAYLOAD;
                        end
                    end
                    mpf_pkg::PH_PAYLOAD: begin
                        seen_next = seen_next + 8'd1;
                        if (seen_next >= len_next) begin
                            chk_due = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase

                // full packet goes out first
                if (fill_next == mpf_pkg::SLOT_END) begin
                    res0_data = store_next;
                    res0_last = 1'b0;
                    push_cnt  = 2'd1;
                    fill_next = mpf_pkg::FIRST_SLOT;
                end

                // checksum byte closes the message
                if (chk_due) begin
                    if (fill_next == mpf_pkg::FIRST_SLOT) begin
                        store_next[0] = seq_next;
                        sum_next      = mpf_pkg::eac_add(sum_next, seq_next);
                        seq_next      = seq_next + 8'd1;
                        fill_next     = fill_next + 4'd1;
                    end
                    widx             = 3'(fill_next - mpf_pkg::FIRST_SLOT);
                    store_next[widx] = sum_next;
                    fill_next        = fill_next + 4'd1;
                    if (push_cnt == 2'd1) begin
                        res1_data = store_next;
                        res1_last = 1'b1;
                    end else begin
                        res0_data = store_next;
                        res0_last = 1'b1;
                    end
                    push_cnt = push_cnt + 2'd1;
                    if (fill_next == mpf_pkg::SLOT_END) begin
                        fill_next = mpf_pkg::FIRST_SLOT;
                    end
                    phase_next = mpf_pkg::PH_DONE;
                end
            end
        end
    end

    // Framing state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= 8'd0;
            seq_reg   <= 8'd0;
            fill_reg  <= mpf_pkg::FIRST_SLOT;
            phase_reg <= mpf_pkg::PH_DONE;
            len_reg   <= 8'd0;
            seen_reg  <= 8'd0;
            store_reg <= '0;
        end else begin
            sum_reg   <= sum_next;
            seq_reg   <= seq_next;
            fill_reg  <= fill_next;
            phase_reg <= phase_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            store_reg <= store_next;
        end
    end

    // Output queue storage
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            q_data_reg[wr_ptr_reg] <= res0_data;
            q_last_reg[wr_ptr_reg] <= res0_last;
        end
        if (push_cnt == 2'd2) begin
            q_data_reg[mpf_pkg::ptr_inc(wr_ptr_reg)] <= res1_data;
            q_last_reg[mpf_pkg::ptr_inc(wr_ptr_reg)] <= res1_last;
        end
    end

    // Output queue pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 2'd0;
        end else begin
            case (push_cnt)
                2'd1:    wr_ptr_reg <= mpf_pkg::ptr_inc(wr_ptr_reg);
                2'd2:    wr_ptr_reg <= mpf_pkg::ptr_inc(mpf_pkg::ptr_inc(wr_ptr_reg));
                default: wr_ptr_reg <= wr_ptr_reg;
            endcase
            if (m_fire) begin
                rd_ptr_reg <= mpf_pkg::ptr_inc(rd_ptr_reg);
            end
            cnt_reg <= cnt_reg + push_cnt - {1'b0, m_fire};
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = q_data_reg[rd_ptr_reg];
    assign m_tlast  = q_last_reg[rd_ptr_reg];

    // Checks
    `MPF_ASSERT_INV(a_room_when_ready, aclk, aresetn, !s_tready || cnt_reg <= 2'd1, "ready with queue too full")
    `MPF_ASSERT_INV(a_fill_range, aclk, aresetn, fill_reg >= mpf_pkg::FIRST_SLOT && fill_reg < mpf_pkg::SLOT_END, "fill position out of range")
    `MPF_ASSERT_PROP(a_len_then_id, aclk, aresetn, (s_fire && s_tuser) |=> (phase_reg == mpf_pkg::PH_ID), "length byte not followed by id phase")
    `MPF_ASSERT_PROP(a_idle_no_push, aclk, aresetn, (s_fire && !s_tuser && phase_reg == mpf_pkg::PH_DONE) |=> (cnt_reg <= $past(cnt_reg)), "packet from a byte outside a message")

endmodule

@@ tb/message_to_packet_framer_unit_test.sv @@
// ---------------------------------------------------------------------------
// message_to_packet_framer_unit_test
// Self-checking bench for the message to packet framer. A cycle-free model
// of the framing rules predicts every packet from the accepted input beats;
// each packet beat is checked field by field against the oldest prediction.
// Directed messages cover the corner cases, then random messages run under
// several sender idle / receiver stall mixes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module message_to_packet_framer_unit_test;

    localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 20;
    localparam int PRINT_CAP    = 100;

    typedef struct {
        mpf_pkg::pkt_t bytes;
        logic          last;
    } packet_beat_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;  // [7:0] data_byte
    logic        s_tuser  = 1'b0;   // [0] start_of_message
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // [7:0] packet_byte_0 .. [47:40] packet_byte_5
    logic        m_tlast;           // last_packet

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    packet_beat_t pending_packets[$];

    // Framing model state
    logic [7:0]       chk_sum;
    logic [3:0]       fill_pos;
    mpf_pkg::phase_t  frm_phase;
    logic [7:0]       seq_num;
    logic [7:0]       msg_len;
    logic [7:0]       payload_cnt;
    mpf_pkg::pkt_t    slot_bytes;

    message_to_packet_framer_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------
    // Framing model
    // ---------------------------------------------------------------------
    function automatic logic [7:0] eac_sum(input logic [7:0] a, input logic [7:0] c);
        logic [8:0] t;
        t = {1'b0, a} + {1'b0, c};
        return (t > 9'h0FF) ? t[7:0] + 8'd1 : t[7:0];
    endfunction

    // State after reset: waiting for a start, store cleared
    task automatic model_reset();
        chk_sum     = 8'd0;
        fill_pos    = mpf_pkg::FIRST_SLOT;
        frm_phase   = mpf_pkg::PH_DONE;
        seq_num     = 8'd0;
        msg_len     = 8'd0;
        payload_cnt = 8'd0;
        slot_bytes  = '0;
        pending_packets.delete();
    endtask

    task automatic put_slot(input logic [7:0] v);
        if (fill_pos >= mpf_pkg::FIRST_SLOT && fill_pos < mpf_pkg::SLOT_END) begin
            slot_bytes[3'(fill_pos - mpf_pkg::FIRST_SLOT)] = v;
            fill_pos = fill_pos + 4'd1;
        end
    endtask

    // A fresh packet opens with the sequence byte
    task automatic open_packet();
        if (fill_pos == mpf_pkg::FIRST_SLOT) begin
            put_slot(seq_num);
            chk_sum = eac_sum(chk_sum, seq_num);
            seq_num = seq_num + 8'd1;
        end
    endtask

    task automatic push_packet(input logic last);
        packet_beat_t p;
        p.bytes = slot_bytes;
        p.last  = last;
        pending_packets.push_back(p);
    endtask

    task automatic frame_byte(input logic [7:0] b, input logic sof);
        logic ends;
        ends = 1'b0;
        if (sof) begin
            chk_sum     = 8'd0;
            seq_num     = 8'd0;
            fill_pos    = mpf_pkg::FIRST_SLOT;
            payload_cnt = 8'd0;
            frm_phase   = mpf_pkg::PH_LEN;
        end
        if (frm_phase != mpf_pkg::PH_DONE) begin
            open_packet();
            put_slot(b);
            chk_sum = eac_sum(chk_sum, b);
            case (frm_phase)
                mpf_pkg::PH_LEN: begin
                    msg_len   = b;
                    frm_phase = mpf_pkg::PH_ID;
                end
                mpf_pkg::PH_ID: begin
                    if (msg_len == 8'd0)
                        ends = 1'b1;
                    else
                        frm_phase = mpf_pkg::PH_PAYLOAD;
                end
                default: begin
                    payload_cnt = payload_cnt + 8'd1;
                    if (payload_cnt >= msg_len)
                        ends = 1'b1;
                end
            endcase
            if (fill_pos >= mpf_pkg::SLOT_END) begin
                push_packet(1'b0);
                fill_pos = mpf_pkg::FIRST_SLOT;
            end
            // Checksum goes in on its own, in a new packet if needed
            if (ends) begin
                open_packet();
                put_slot(chk_sum);
                push_packet(1'b1);
                if (fill_pos >= mpf_pkg::SLOT_END)
                    fill_pos = mpf_pkg::FIRST_SLOT;
                frm_phase = mpf_pkg::PH_DONE;
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------------
    // Monitor: predict on input beats, check output beats, watch for stalls
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        packet_beat_t exp_pkt;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                frame_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                if (pending_packets.size() == 0) begin
                    report_mismatch($sformatf("unexpected packet %h last %b", m_tdata, m_tlast));
                end else begin
                    exp_pkt = pending_packets.pop_front();
                    for (int i = 0; i < mpf_pkg::PKT_BYTES; i++) begin
                        if (m_tdata[8*i +: 8] !== exp_pkt.bytes[i])
                            report_mismatch($sformatf("packet_byte_%0d got %h want %h",
                                                      i, m_tdata[8*i +: 8], exp_pkt.bytes[i]));
                    end
                    if (m_tlast !== exp_pkt.last)
                        report_mismatch($sformatf("last_packet got %b want %b",
                                                  m_tlast, exp_pkt.last));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end else begin
            model_reset();
        end
    end

    // Receiver backpressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog
    initial begin : watchdog
        do @(posedge aclk); while (quiet_cycles < QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    // Entered and left at a falling edge; holds the beat until accepted
    task automatic send_byte(input logic [7:0] b, input logic sof);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // After reset the framer waits for a start; plain bytes do nothing
    task automatic test_ignored_before_start();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // Zero length: checksum right after the id byte
    task automatic test_zero_length();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
    endtask

    // Last payload byte fills the packet: full packet, then checksum packet.
    // A trailing byte without start is ignored.
    task automatic test_full_then_checksum();
        send_byte(8'h03, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hA5, 1'b0);
    endtask

    // Checksum lands in the last slot; the packet goes out once
    task automatic test_checksum_fills_packet();
        send_byte(8'h02, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // New start mid-message drops the partial packet, stale bytes remain
    task automatic test_restart_mid_message();
        send_byte(8'h0A, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b0);
    endtask

    // Mostly well-formed messages, some cut short or restarted, some noise
    task automatic test_random_messages(input int n_items, input int idle, input int stall);
        int sent;
        int len;
        int n_bytes;
        int r;
        logic sof;
        sent = 0;
        send_idle_pct = idle;
        stall_pct     = stall;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 80)
                len = $urandom_range(12);
            else if (r < 95)
                len = $urandom_range(60, 13);
            else
                len = $urandom_range(255, 61);
            n_bytes = len + 2;
            if ($urandom_range(99) < 6)
                n_bytes = $urandom_range(len + 1, 1);
            for (int i = 0; i < n_bytes; i++) begin
                sof = (i == 0) || ($urandom_range(199) == 0);
                send_byte((i == 0) ? 8'(len) : 8'($urandom_range(255)), sof);
                sent++;
            end
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(3, 1))
                    send_byte(8'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    initial begin : main
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_ignored_before_start();
        test_zero_length();
        test_full_then_checksum();
        test_checksum_fills_packet();
        test_restart_mid_message();

        test_random_messages(340, 0, 0);
        test_random_messages(340, 66, 0);
        test_random_messages(340, 0, 66);
        test_random_messages(340, 33, 33);

        s_tvalid <= 1'b0;
        while (pending_packets.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_packets.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
